[design/mgfp_pkg.sv]
package mgfp_pkg;

    // Result queue depth; must be a power of two and at least four.
    localparam int MGFP_QUEUE_DEPTH = 8;

    localparam logic [23:0] WINDOW_IDLE = 24'hFFFFFF;
    localparam logic [23:0] PREFIX_SEEN = 24'h000001;

    localparam logic [7:0] CODE_PICTURE     = 8'h00;
    localparam logic [7:0] CODE_GROUP       = 8'hB8;
    localparam logic [7:0] CODE_EXTENSION   = 8'hB5;
    localparam logic [7:0] CODE_USER_DATA   = 8'hB2;
    localparam logic [7:0] CODE_PROGRAM_END = 8'hB9;

    localparam logic [3:0] PIC_CODING_EXT_ID = 4'h8;

    // Extension payload step: 0 is idle, otherwise the index of the next payload byte plus one.
    localparam logic [2:0] EXT_IDLE       = 3'd0;
    localparam logic [2:0] EXT_STEP_FIRST = 3'd1;
    localparam logic [2:0] EXT_STEP_FLAGS = 3'd4;
    localparam logic [2:0] EXT_STEP_LAST  = 3'd7;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] gop_record;
        logic       top_first;
        logic [7:0] picture_count;
        logic [7:0] repeat_field_count;
        logic       error_flag;
        logic       is_final;
    } record_t;

    typedef struct packed {
        logic       pending;
        logic [1:0] count;
        record_t    first;
        record_t    second;
    } push_t;

    localparam record_t ERROR_RECORD = '{
        gop_record:         8'd0,
        top_first:          1'b0,
        picture_count:      8'd0,
        repeat_field_count: 8'd0,
        error_flag:         1'b1,
        is_final:           1'b0
    };

    function automatic record_t make_record(input logic       pattern,
                                            input logic [7:0] frames,
                                            input logic [7:0] repeats,
                                            input logic       fin);
        record_t r;
        r.gop_record         = {pattern, 7'd0} + {frames[6:0], 1'b0} + repeats;
        r.top_first          = pattern;
        r.picture_count      = frames;
        r.repeat_field_count = repeats;
        r.error_flag         = 1'b0;
        r.is_final           = fin;
        return r;
    endfunction

endpackage

[design/mgfp_if.sv]
interface mgfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       end_of_stream;

    modport source (output valid, output stream_byte, output end_of_stream, input ready);
    modport sink (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface mgfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gop_record;
    logic       top_first;
    logic [7:0] picture_count;
    logic [7:0] repeat_field_count;
    logic       error_flag;
    logic       is_final;

    modport source (output valid, output gop_record, output top_first,
                    output picture_count, output repeat_field_count,
                    output error_flag, output is_final, input ready);
    modport sink (input valid, input gop_record, input top_first,
                  input picture_count, input repeat_field_count,
                  input error_flag, input is_final, output ready);
endinterface

[design/mpeg_gop_field_pattern_counter.sv]
// A byte taken at a clock edge is held in the input register and processed in the next
// cycle; its records are then written into the result queue, whose head drives the output.
// Throughput: one byte per cycle while the result queue has room; a byte giving two
// records (group code on the last byte) is absorbed by the result queue.
// Reset: rst_n is asynchronous and active low; it empties the result queue and
// returns the scanner, extension tracker, counts and stop flag to their idle values.
module mpeg_gop_field_pattern_counter
    import mgfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = MGFP_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    mgfp_in_if.sink       stream,
    mgfp_out_if.source    records
);

    push_t push;
    logic  room;

    mgfp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .room   (room),
        .push   (push)
    );

    mgfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .records (records)
    );

    // When a byte produces two records, the second one always closes the stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.second.is_final && !push.first.error_flag))
        else $error("second record of a byte is not a final record");

    // An error record carries no counts and never closes the stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && records.error_flag) |->
            (!records.is_final && records.gop_record == 8'd0 && records.picture_count == 8'd0))
        else $error("error record carries counts or final mark");

    // An accepted transaction is always processed in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.ready) |=> push.pending)
        else $error("accepted byte was not processed");

endmodule

[design/mgfp_parser.sv]
module mgfp_parser
    import mgfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mgfp_in_if.sink       stream,
    input  logic          room,
    output push_t         push
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       eos_reg;

    logic [23:0] window_reg, window_next;
    logic [2:0]  step_reg, step_next;
    logic        pattern_reg, pattern_next;
    logic [7:0]  frames_reg, frames_next;
    logic [7:0]  repeats_reg, repeats_next;
    logic        stopped_reg, stopped_next;

    logic    accept;
    logic    step_valid;
    logic    final_valid;
    record_t step_rec;
    record_t final_rec;

    assign stream.ready = room;
    assign accept       = stream.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= stream.stream_byte;
            eos_reg  <= stream.end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_IDLE;
            step_reg    <= EXT_IDLE;
            pattern_reg <= 1'b0;
            frames_reg  <= 8'd0;
            repeats_reg <= 8'd0;
            stopped_reg <= 1'b0;
        end
        else if (valid_reg)
        begin
            window_reg  <= window_next;
            step_reg    <= step_next;
            pattern_reg <= pattern_next;
            frames_reg  <= frames_next;
            repeats_reg <= repeats_next;
            stopped_reg <= stopped_next;
        end
    end

    always_comb
    begin
        window_next  = window_reg;
        step_next    = step_reg;
        pattern_next = pattern_reg;
        frames_next  = frames_reg;
        repeats_next = repeats_reg;
        stopped_next = stopped_reg;
        step_valid   = 1'b0;
        step_rec     = make_record(pattern_reg, frames_reg, repeats_reg, 1'b0);
        final_valid  = 1'b0;

        if (!stopped_reg)
        begin
            if (step_reg != EXT_IDLE)
            begin
                // Extension payload bytes are consumed without start code scanning.
                if (step_reg == EXT_STEP_FIRST && byte_reg[7:4] != PIC_CODING_EXT_ID)
                begin
                    step_next = EXT_IDLE;
                end
                else
                begin
                    if (step_reg == EXT_STEP_FLAGS)
                    begin
                        pattern_next = byte_reg[7];
                        if (byte_reg[1] && repeats_reg != COUNT_MAX)
                        begin
                            repeats_next = repeats_reg + 8'd1;
                        end
                    end
                    step_next = (step_reg == EXT_STEP_LAST) ? EXT_IDLE : step_reg + 3'd1;
                end
                window_next = WINDOW_IDLE;
            end
            else if (window_reg == PREFIX_SEEN)
            begin
                window_next = WINDOW_IDLE;
                case (byte_reg)
                    CODE_PICTURE:
                    begin
                        if (frames_reg != COUNT_MAX)
                        begin
                            frames_next = frames_reg + 8'd1;
                        end
                    end
                    CODE_GROUP:
                    begin
                        step_valid   = 1'b1;
                        pattern_next = 1'b0;
                        frames_next  = 8'd0;
                        repeats_next = 8'd0;
                    end
                    CODE_EXTENSION:
                    begin
                        step_next = EXT_STEP_FIRST;
                    end
                    CODE_USER_DATA:
                    begin
                        step_valid   = 1'b1;
                        step_rec     = ERROR_RECORD;
                        stopped_next = 1'b1;
                    end
                    CODE_PROGRAM_END:
                    begin
                        step_valid   = 1'b1;
                        step_rec     = make_record(pattern_reg, frames_reg, repeats_reg, 1'b1);
                        stopped_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                window_next = {window_reg[15:0], byte_reg};
            end
        end

        final_rec = make_record(pattern_next, frames_next, repeats_next, 1'b1);

        if (eos_reg)
        begin
            final_valid  = !stopped_next;
            window_next  = WINDOW_IDLE;
            step_next    = EXT_IDLE;
            pattern_next = 1'b0;
            frames_next  = 8'd0;
            repeats_next = 8'd0;
            stopped_next = 1'b0;
        end
    end

    always_comb
    begin
        push.pending = valid_reg;
        push.count   = valid_reg ? ({1'b0, step_valid} + {1'b0, final_valid}) : 2'd0;
        push.first   = step_valid ? step_rec : final_rec;
        push.second  = final_rec;
    end

endmodule

[design/mgfp_queue.sv]
module mgfp_queue
    import mgfp_pkg::*;
#(
    parameter int DEPTH = MGFP_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    output logic          room,
    mgfp_out_if.source    records
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    record_t         mem [DEPTH];
    logic [PW-1:0]   head_reg, head_next;
    logic [PW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW:0]     need;
    logic            pop;
    record_t         head_rec;

    assign pop      = records.valid && records.ready;
    assign head_rec = mem[head_reg];

    // A transaction taken now may push two records after the one in flight pushes its own two.
    assign need = {1'b0, count_reg} + (push.pending ? (CW+1)'(4) : (CW+1)'(2));
    assign room = need <= (CW+1)'(DEPTH);

    always_comb
    begin
        head_next  = head_reg + PW'(pop);
        tail_next  = tail_reg + PW'(push.count);
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[tail_reg + PW'(1)] <= push.second;
        end
    end

    assign records.valid              = count_reg != '0;
    assign records.gop_record         = head_rec.gop_record;
    assign records.top_first          = head_rec.top_first;
    assign records.picture_count      = head_rec.picture_count;
    assign records.repeat_field_count = head_rec.repeat_field_count;
    assign records.error_flag         = head_rec.error_flag;
    assign records.is_final           = head_rec.is_final;

endmodule
